>>> design/smoothstep_color_band_blend_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker of the smoothstep color band blend unit.
// ----------------------------------------------------------------------------
`ifndef SMOOTHSTEP_COLOR_BAND_BLEND_UNIT_DEFINES_SVH
`define SMOOTHSTEP_COLOR_BAND_BLEND_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scbb: implication check failed");

// Next-cycle implication, checked outside reset.
`define SCBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scbb: next-cycle check failed");

// Next-cycle implication that is also checked while reset is applied.
`define SCBB_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("scbb: reset behavior check failed");

`endif

>>> design/scbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbb_pkg
// Constants, register codes and types shared by the smoothstep color band
// blend unit and its pipeline parts.
// ----------------------------------------------------------------------------
package scbb_pkg;

    // Band and number format configuration.
    localparam int NUM_BANDS     = 5;
    localparam int FRACTION_BITS = 16;
    localparam int NUM_THR       = NUM_BANDS - 1;
    localparam int BAND_IDX_W    = (NUM_THR > 1) ? $clog2(NUM_THR) : 1;
    localparam int FRAC_ONE_W    = FRACTION_BITS + 1;
    localparam int DIV_STEPS     = FRACTION_BITS + 1;
    localparam int HEIGHT_W      = 18;

    // Register file layout.
    localparam int THR_REG_W     = 64;
    localparam int COLOR_W       = 24;
    localparam int CHAN_W        = 8;
    localparam int COLOR_REGS    = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLDS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FIRST = CFG_IDX_W'(1);

    localparam logic [THR_REG_W-1:0] THR_RESET = 64'hFFFF_C000_8000_0000;

    // Fixed-point one, as wide as it needs to be.
    localparam logic [FRAC_ONE_W-1:0] FRAC_ONE = FRAC_ONE_W'(1) << FRACTION_BITS;

    typedef logic [COLOR_W-1:0] t_color;
    typedef t_color [COLOR_REGS-1:0] t_color_bank;

    // Colors of the lower and upper band of an item.
    typedef struct packed {
        t_color lo;
        t_color hi;
    } t_color_pair;

    // What the band search hands to the divider.
    typedef struct packed {
        logic [FRACTION_BITS-1:0] num;
        logic [FRACTION_BITS-1:0] span;
        logic                     zero;
        t_color_pair              colors;
    } t_band_item;

    // One blended result.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

endpackage

>>> design/scbb_band_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbb_band_select
// First pipeline stage: clamps the height, finds its band and forms the
// division operands and the two band colors.
// ----------------------------------------------------------------------------
module scbb_band_select import scbb_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [HEIGHT_W-1:0]  i_height_level,
    input  logic [THR_REG_W-1:0]        i_thresholds,
    input  t_color_bank                 i_colors,
    output logic                        o_valid,
    output t_band_item                  o_item
);

    logic [FRACTION_BITS-1:0] height_clamped;
    logic [FRACTION_BITS-1:0] thr    [NUM_THR];
    logic [FRACTION_BITS-1:0] lo_arr [NUM_THR];
    t_color                   band_col [NUM_BANDS];
    logic                     found;
    logic [BAND_IDX_W-1:0]    sel_idx;
    logic [FRACTION_BITS-1:0] hi;
    logic [FRACTION_BITS-1:0] lo;
    t_band_item               n_item;
    logic                     r_valid;
    t_band_item               r_item;

    // Bands past the color registers are black.
    for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band_col
        if (b < COLOR_REGS) begin : g_reg
            assign band_col[b] = i_colors[b];
        end else begin : g_black
            assign band_col[b] = '0;
        end
    end

    // Clamp the height to the unit interval.
    always_comb begin
        if (i_height_level[HEIGHT_W-1]) begin
            height_clamped = '0;
        end else if (i_height_level > $signed(HEIGHT_W'(FRAC_ONE - 1'b1))) begin
            height_clamped = '1;
        end else begin
            height_clamped = i_height_level[FRACTION_BITS-1:0];
        end
    end

    // Unpack the thresholds; slots past the register read as zero.
    always_comb begin
        for (int k = 0; k < NUM_THR; k++) begin
            thr[k] = FRACTION_BITS'(i_thresholds >> (k * FRACTION_BITS));
        end
        lo_arr[0] = '0;
        for (int k = 1; k < NUM_THR; k++) begin
            lo_arr[k] = thr[k-1];
        end
    end

    // First threshold that the height does not exceed.
    always_comb begin
        found   = 1'b0;
        sel_idx = '0;
        for (int k = 0; k < NUM_THR; k++) begin
            if (!found && (height_clamped <= thr[k])) begin
                found   = 1'b1;
                sel_idx = BAND_IDX_W'(k);
            end
        end
    end

    // Operands of the division and the colors to blend. Above every
    // threshold both colors are the last band's and the fraction is zero.
    always_comb begin
        hi                = '0;
        lo                = '0;
        n_item.colors.lo  = band_col[NUM_BANDS-1];
        n_item.colors.hi  = band_col[NUM_BANDS-1];
        for (int k = 0; k < NUM_THR; k++) begin
            if (found && (sel_idx == BAND_IDX_W'(k))) begin
                hi               = thr[k];
                lo               = lo_arr[k];
                n_item.colors.lo = band_col[k];
                n_item.colors.hi = band_col[k+1];
            end
        end
        n_item.span = hi - lo;
        n_item.zero = !(found && (hi > lo));
        n_item.num  = (height_clamped > lo) ? (height_clamped - lo) : '0;
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> design/scbb_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbb_divider
// Pipelined restoring divider: one quotient bit per stage gives the band
// fraction num * one / span, which never exceeds one.
// ----------------------------------------------------------------------------
module scbb_divider import scbb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_band_item             i_item,
    output logic                   o_valid,
    output logic [FRAC_ONE_W-1:0]  o_frac,
    output t_color_pair            o_colors
);

    logic                     r_vld  [DIV_STEPS];
    logic [FRAC_ONE_W-1:0]    r_rem  [DIV_STEPS];
    logic [FRAC_ONE_W-1:0]    r_quo  [DIV_STEPS];
    logic [FRACTION_BITS-1:0] r_span [DIV_STEPS];
    logic                     r_zero [DIV_STEPS];
    t_color_pair              r_col  [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic                     vld_in;
        logic [FRAC_ONE_W-1:0]    rem_in;
        logic [FRAC_ONE_W-1:0]    quo_in;
        logic [FRACTION_BITS-1:0] span_in;
        logic                     zero_in;
        t_color_pair              col_in;
        logic [FRAC_ONE_W-1:0]    trial;
        logic                     fits;
        logic [FRAC_ONE_W-1:0]    n_rem;
        logic [FRAC_ONE_W-1:0]    n_quo;

        // The first step tests the integer bit, later steps shift first.
        if (j == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = {1'b0, i_item.num};
            assign quo_in  = '0;
            assign span_in = i_item.span;
            assign zero_in = i_item.zero;
            assign col_in  = i_item.colors;
            assign trial   = rem_in;
        end else begin : g_next
            assign vld_in  = r_vld[j-1];
            assign rem_in  = r_rem[j-1];
            assign quo_in  = r_quo[j-1];
            assign span_in = r_span[j-1];
            assign zero_in = r_zero[j-1];
            assign col_in  = r_col[j-1];
            assign trial   = {rem_in[FRAC_ONE_W-2:0], 1'b0};
        end

        // Compare and subtract for one quotient bit.
        assign fits  = (trial >= {1'b0, span_in});
        assign n_rem = fits ? (trial - {1'b0, span_in}) : trial;
        assign n_quo = {quo_in[FRAC_ONE_W-2:0], fits};

        // Stage valid bit.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        // Stage payload.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_quo[j]  <= n_quo;
                r_span[j] <= span_in;
                r_zero[j] <= zero_in;
                r_col[j]  <= col_in;
            end
        end
    end

    // A band without positive span blends with fraction zero.
    assign o_valid  = r_vld[DIV_STEPS-1];
    assign o_frac   = r_zero[DIV_STEPS-1] ? '0 : r_quo[DIV_STEPS-1];
    assign o_colors = r_col[DIV_STEPS-1];

endmodule

>>> design/scbb_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbb_shaper
// Two stages of smoothstep: f*f first, then f*f*(3 - 2f), both in
// Q.FRACTION_BITS with truncation.
// ----------------------------------------------------------------------------
module scbb_shaper import scbb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [FRAC_ONE_W-1:0]  i_frac,
    input  t_color_pair            i_colors,
    output logic                   o_valid,
    output logic [FRAC_ONE_W-1:0]  o_shaped,
    output t_color_pair            o_colors
);

    localparam int W_W  = FRACTION_BITS + 2;
    localparam int SQ_W = 2 * FRAC_ONE_W;
    localparam int P_W  = FRAC_ONE_W + W_W;
    localparam int S_W  = P_W - FRACTION_BITS;
    localparam logic [W_W-1:0] THREE_ONE = W_W'(3) << FRACTION_BITS;

    logic [FRAC_ONE_W-1:0] frac_sat;
    logic [SQ_W-1:0]       square;
    logic [W_W-1:0]        weight;
    logic [P_W-1:0]        product;
    logic [S_W-1:0]        shaped_raw;
    logic [FRAC_ONE_W-1:0] n_shaped;

    logic                  r_vld_a;
    logic [FRAC_ONE_W-1:0] r_f;
    logic [FRAC_ONE_W-1:0] r_f2;
    t_color_pair           r_col_a;
    logic                  r_vld_b;
    logic [FRAC_ONE_W-1:0] r_s;
    t_color_pair           r_col_b;

    // Stage A: saturate the fraction and square it.
    assign frac_sat = (i_frac > FRAC_ONE) ? FRAC_ONE : i_frac;
    assign square   = frac_sat * frac_sat;

    // Stage B: multiply by (3 - 2f) and keep the result within one.
    assign weight     = THREE_ONE - {r_f, 1'b0};
    assign product    = r_f2 * weight;
    assign shaped_raw = product[P_W-1:FRACTION_BITS];
    assign n_shaped   = (shaped_raw > S_W'(FRAC_ONE)) ? FRAC_ONE
                                                      : shaped_raw[FRAC_ONE_W-1:0];

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f     <= frac_sat;
            r_f2    <= square[FRACTION_BITS +: FRAC_ONE_W];
            r_col_a <= i_colors;
            r_s     <= n_shaped;
            r_col_b <= r_col_a;
        end
    end

    assign o_valid  = r_vld_b;
    assign o_shaped = r_s;
    assign o_colors = r_col_b;

endmodule

>>> design/scbb_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbb_blend
// Two stages of per-channel linear blend: weighted products first, then the
// rounded sum.
// ----------------------------------------------------------------------------
module scbb_blend import scbb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [FRAC_ONE_W-1:0]  i_shaped,
    input  t_color_pair            i_colors,
    output logic                   o_valid,
    output t_rgb                   o_rgb
);

    localparam int CHANNELS = 3;
    localparam int PROD_W   = CHAN_W + FRAC_ONE_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRACTION_BITS - 1);

    logic [FRAC_ONE_W-1:0] inv_shaped;
    logic [PROD_W-1:0]     n_pa [CHANNELS];
    logic [PROD_W-1:0]     n_pb [CHANNELS];
    logic [SUM_W-1:0]      total [CHANNELS];
    logic [CHAN_W-1:0]     chan  [CHANNELS];

    logic                  r_vld_a;
    logic [PROD_W-1:0]     r_pa [CHANNELS];
    logic [PROD_W-1:0]     r_pb [CHANNELS];
    logic                  r_vld_b;
    t_rgb                  r_rgb;

    assign inv_shaped = FRAC_ONE - i_shaped;

    // Stage A: weight the two band colors, channel 0 is red in the top byte.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_pa[c] = i_colors.lo[(CHANNELS-1-c)*CHAN_W +: CHAN_W] * inv_shaped;
            n_pb[c] = i_colors.hi[(CHANNELS-1-c)*CHAN_W +: CHAN_W] * i_shaped;
        end
    end

    // Stage B: add, round half up and drop the fraction.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            total[c] = {1'b0, r_pa[c]} + {1'b0, r_pb[c]} + HALF;
            chan[c]  = total[c][FRACTION_BITS +: CHAN_W];
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa        <= n_pa;
            r_pb        <= n_pb;
            r_rgb.red   <= chan[0];
            r_rgb.green <= chan[1];
            r_rgb.blue  <= chan[2];
        end
    end

    assign o_valid = r_vld_b;
    assign o_rgb   = r_rgb;

endmodule

>>> design/smoothstep_color_band_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothstep_color_band_blend_unit
// Height to color ramp: band search, pipelined division, smoothstep shaping
// and per-channel blending of the two neighboring band colors.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_stall   i_height_level
//   output    out        o_out_valid / i_out_stall o_red, o_green, o_blue
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle is taken and delivered while neither side stalls.
// Items pass search, the 17 one-bit-per-stage divider stages, shaping and blend.
// Reset clears all valid bits, restores the default thresholds and sets the
// band colors to black. An output register and one skid entry follow the
// pipeline; o_in_stall rises only once the skid entry holds an item, and the
// whole pipeline then holds until the output is taken.
// ----------------------------------------------------------------------------
module smoothstep_color_band_blend_unit import scbb_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [HEIGHT_W-1:0]  i_height_level,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [CHAN_W-1:0]           o_red,
    output logic [CHAN_W-1:0]           o_green,
    output logic [CHAN_W-1:0]           o_blue,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    logic [THR_REG_W-1:0]  r_thresholds;
    t_color_bank           r_colors;

    logic                  pipe_en;
    logic                  sel_valid;
    t_band_item            sel_item;
    logic                  div_valid;
    logic [FRAC_ONE_W-1:0] div_frac;
    t_color_pair           div_colors;
    logic                  shp_valid;
    logic [FRAC_ONE_W-1:0] shp_shaped;
    t_color_pair           shp_colors;
    logic                  tail_valid;
    t_rgb                  tail_rgb;

    logic                  r_out_vld;
    t_rgb                  r_out_rgb;
    logic                  r_skid_vld;
    t_rgb                  r_skid_rgb;
    logic                  out_take;
    logic                  out_free;
    logic                  tail_leaves;

    // Configuration registers; writes to unused indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresholds <= THR_RESET;
            r_colors     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_THRESHOLDS) begin
                r_thresholds <= i_cfg_data;
            end
            for (int k = 0; k < COLOR_REGS; k++) begin
                if (i_cfg_index == (CFG_COLOR_FIRST + CFG_IDX_W'(k))) begin
                    r_colors[k] <= i_cfg_data[COLOR_W-1:0];
                end
            end
        end
    end

    // The pipeline moves whenever the skid entry is free.
    assign pipe_en    = !r_skid_vld;
    assign o_in_stall = r_skid_vld;

    scbb_band_select u_band_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (pipe_en),
        .i_valid        (i_in_valid),
        .i_height_level (i_height_level),
        .i_thresholds   (r_thresholds),
        .i_colors       (r_colors),
        .o_valid        (sel_valid),
        .o_item         (sel_item)
    );

    scbb_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (sel_valid),
        .i_item   (sel_item),
        .o_valid  (div_valid),
        .o_frac   (div_frac),
        .o_colors (div_colors)
    );

    scbb_shaper u_shaper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (div_valid),
        .i_frac   (div_frac),
        .i_colors (div_colors),
        .o_valid  (shp_valid),
        .o_shaped (shp_shaped),
        .o_colors (shp_colors)
    );

    scbb_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (shp_valid),
        .i_shaped (shp_shaped),
        .i_colors (shp_colors),
        .o_valid  (tail_valid),
        .o_rgb    (tail_rgb)
    );

    // Output register with one skid entry behind it.
    assign out_take    = r_out_vld && !i_out_stall;
    assign out_free    = !r_out_vld || out_take;
    assign tail_leaves = pipe_en && tail_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_vld <= r_skid_vld || tail_leaves;
            end
            if (r_skid_vld) begin
                r_skid_vld <= !out_take;
            end else begin
                r_skid_vld <= tail_leaves && !out_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_rgb <= r_skid_vld ? r_skid_rgb : tail_rgb;
        end
        if (!r_skid_vld && tail_leaves && !out_free) begin
            r_skid_rgb <= tail_rgb;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_red       = r_out_rgb.red;
    assign o_green     = r_out_rgb.green;
    assign o_blue      = r_out_rgb.blue;

endmodule

>>> design/scbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbb_checker
// Port-level checks of the smoothstep color band blend unit, bound to the top.
// ----------------------------------------------------------------------------
`include "smoothstep_color_band_blend_unit_defines.svh"

module scbb_checker import scbb_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_in_stall,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [CHAN_W-1:0]          o_red,
    input  logic [CHAN_W-1:0]          o_green,
    input  logic [CHAN_W-1:0]          o_blue
);

    logic                  out_held;
    logic [3*CHAN_W-1:0]   out_rgb;

    // A result is waiting while the receiver stalls it.
    assign out_held = o_out_valid && i_out_stall;
    assign out_rgb  = {o_red, o_green, o_blue};

    // Reset empties the output register.
    `SCBB_ASSERT_ALWAYS_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !o_out_valid)

    // A stalled result stays and does not change.
    `SCBB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_rgb))

    // The input side stalls only while a result is waiting.
    `SCBB_ASSERT_IMPLY(a_stall_needs_result, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // The input side begins to stall only after the output was stalled.
    `SCBB_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall), $past(out_held))

endmodule

bind smoothstep_color_band_blend_unit scbb_checker u_scbb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_red          (o_red),
    .o_green        (o_green),
    .o_blue         (o_blue)
);

>>> bench/tb_smoothstep_color_band_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothstep_color_band_blend_unit
// Self-checking bench for the height to color ramp. A predictor of its own
// computes the band search, fraction, smoothstep shaping and channel blend for
// every accepted height and keeps the expected colors in order. Directed tests
// cover clamping, band edges, the zero span, heights past the last threshold
// and ignored register indexes. Random phases follow with changing settings
// and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_smoothstep_color_band_blend_unit;
    import scbb_pkg::*;

    localparam int SETTLE_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 104;

    // Register indexes past the color registers; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_COLOR_FIRST + COLOR_REGS);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(CFG_COLOR_FIRST + COLOR_REGS + 1);

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_stall;
    logic signed [HEIGHT_W-1:0] i_height_level = '0;
    logic                       o_out_valid;
    logic                       i_out_stall    = 1'b0;
    logic [CHAN_W-1:0]          o_red;
    logic [CHAN_W-1:0]          o_green;
    logic [CHAN_W-1:0]          o_blue;
    logic                       i_cfg_valid    = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data     = '0;

    // Mirror of the register file, updated when a write is taken.
    logic [THR_REG_W-1:0] limits_mirror = THR_RESET;
    t_color               palette_mirror [COLOR_REGS];

    t_rgb expected_colors [$];

    int mismatch_count  = 0;
    int heights_sent    = 0;
    int colors_checked  = 0;
    int reg_writes      = 0;
    int settings_loaded = 0;
    int stall_free      = 0;
    int send_idle_pct   = 10;
    int recv_idle_pct   = 10;

    smoothstep_color_band_blend_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_height_level (i_height_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Threshold slot k of the mirrored register; slots from bit 64 on read as zero.
    function automatic longint band_limit(int k);
        longint pos;
        pos = longint'(k) * FRACTION_BITS;
        if (pos >= THR_REG_W) begin
            return 0;
        end
        return longint'((limits_mirror >> pos) & ((64'd1 << FRACTION_BITS) - 64'd1));
    endfunction

    function automatic t_color palette_color(int b);
        if (b >= NUM_BANDS || b >= COLOR_REGS) begin
            return '0;
        end
        return palette_mirror[b];
    endfunction

    // One channel mixed by the shaped weight, rounded half up.
    function automatic logic [CHAN_W-1:0] mix_channel(longint a, longint b, longint s);
        longint one;
        longint v;
        one = longint'(1) << FRACTION_BITS;
        v = (a * (one - s) + b * s + (one >> 1)) >> FRACTION_BITS;
        return v[CHAN_W-1:0];
    endfunction

    // Expected color for one height under the mirrored settings.
    function automatic t_rgb ramp_color(logic signed [HEIGHT_W-1:0] h);
        longint one;
        longint t;
        longint lo;
        longint hi;
        longint span;
        longint num;
        longint f;
        longint f2;
        longint s;
        t_color c0;
        t_color c1;
        t_rgb   rgb;
        one = longint'(1) << FRACTION_BITS;
        t = h;
        if (t < 0) begin
            t = 0;
        end
        if (t > one - 1) begin
            t = one - 1;
        end
        for (int i = 0; i < NUM_THR; i++) begin
            hi = band_limit(i);
            if (t <= hi) begin
                lo = (i == 0) ? 0 : band_limit(i - 1);
                span = hi - lo;
                f = 0;
                // A zero span leaves the fraction at zero.
                if (span > 0) begin
                    num = t - lo;
                    if (num < 0) begin
                        num = 0;
                    end
                    f = (num << FRACTION_BITS) / span;
                end
                if (f > one) begin
                    f = one;
                end
                f2 = (f * f) >> FRACTION_BITS;
                s = (f2 * (3 * one - 2 * f)) >> FRACTION_BITS;
                if (s > one) begin
                    s = one;
                end
                c0 = palette_color(i);
                c1 = palette_color(i + 1);
                rgb.red   = mix_channel(c0[23:16], c1[23:16], s);
                rgb.green = mix_channel(c0[15:8], c1[15:8], s);
                rgb.blue  = mix_channel(c0[7:0], c1[7:0], s);
                return rgb;
            end
        end
        // Above every threshold the last band color stands as it is.
        return t_rgb'(palette_color(NUM_BANDS - 1));
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH %s", msg);
        mismatch_count++;
    endtask

    // Channel monitor: predicts on every accepted height, checks every result
    // and mirrors every register write that is taken.
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                if (i_cfg_index == CFG_THRESHOLDS) begin
                    limits_mirror = i_cfg_data;
                end else if (i_cfg_index < CFG_SPARE_LO) begin
                    palette_mirror[i_cfg_index - CFG_COLOR_FIRST] = i_cfg_data[COLOR_W-1:0];
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_colors.push_back(ramp_color(i_height_level));
                heights_sent++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                                              o_red, o_green, o_blue));
                end else begin
                    want = expected_colors.pop_front();
                    if (o_red !== want.red) begin
                        report_mismatch($sformatf("result %0d red: expected %0d got %0d",
                                                  colors_checked, want.red, o_red));
                    end
                    if (o_green !== want.green) begin
                        report_mismatch($sformatf("result %0d green: expected %0d got %0d",
                                                  colors_checked, want.green, o_green));
                    end
                    if (o_blue !== want.blue) begin
                        report_mismatch($sformatf("result %0d blue: expected %0d got %0d",
                                                  colors_checked, want.blue, o_blue));
                    end
                end
                colors_checked++;
            end
        end
    end

    // Receiver stalls at random.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog over cycles in which no item and no write is taken.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_free <= 0;
        end else begin
            stall_free <= stall_free + 1;
        end
        if (stall_free >= WATCHDOG_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sends one height; returns at the edge that takes it, valid still high.
    task automatic send_height(int h);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_height_level <= HEIGHT_W'(h);
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every expected color has arrived.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_colors.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; returns at the taking edge with valid still high.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Loads a full setting while the block is idle. Unused data bits get noise.
    task automatic apply_setting(bit with_limits, logic [THR_REG_W-1:0] limits,
                                 t_color_bank colors);
        wait_idle();
        if (with_limits) begin
            write_reg(CFG_THRESHOLDS, limits);
        end
        for (int b = 0; b < COLOR_REGS; b++) begin
            write_reg(CFG_IDX_W'(CFG_COLOR_FIRST + b), {$urandom(), 8'($urandom()), colors[b]});
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_loaded++;
    endtask

    function automatic logic [THR_REG_W-1:0] pack_limits(int a, int b, int c, int d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    // After reset every band is black whatever the height.
    task automatic test_reset_state();
        send_height(0);
        send_height(32'h0000_FFFF);
        send_height(131071);
    endtask

    // Colors only; the thresholds keep their reset values.
    task automatic test_default_limits();
        t_color_bank colors;
        colors = {24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFFFF, 24'h102030};
        apply_setting(1'b0, '0, colors);
        send_height(16'h4000);
        send_height(16'h8000);
        send_height(16'hC000);
        send_height(16'hE000);
        send_height(16'hFFFF);
    endtask

    // Clamping at both ends, heights at or next to every threshold, extreme colors.
    task automatic test_band_edges();
        t_color_bank colors;
        colors = {24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF};
        apply_setting(1'b1, pack_limits(16'h2000, 16'h6000, 16'hA000, 16'hF000), colors);
        send_height(-131072);
        send_height(-1);
        send_height(1);
        send_height(16'h2000);
        send_height(16'h2001);
        send_height(16'h6000);
        send_height(16'hA000);
        send_height(16'hF001);
        send_height(65536);
        send_height(131071);
    endtask

    // First threshold zero: height zero sees a zero span and takes band zero.
    // The last threshold below one sends the top heights to the last band.
    task automatic test_zero_span_and_top();
        t_color_bank colors;
        colors = {24'hA0B0C0, 24'h405060, 24'h0F0F0F, 24'hF0F0F0, 24'h123456};
        apply_setting(1'b1, pack_limits(0, 16'h4000, 16'h4000, 16'hE000), colors);
        send_height(0);
        send_height(1);
        send_height(16'hE001);
        send_height(16'hFFFF);
    endtask

    // Thresholds out of order, then writes to indexes past the list.
    task automatic test_unsorted_and_spare();
        t_color_bank colors;
        colors = {24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h808080, 24'h7F7F7F};
        apply_setting(1'b1, pack_limits(16'hC000, 16'h4000, 16'h8000, 16'h2000), colors);
        send_height(16'hD000);
        wait_idle();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, 64'h5555_AAAA_5555_AAAA);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_height(16'h6000);
        send_height(16'hD000);
    endtask

    // Random setting: mostly ascending thresholds, some raw or extreme ones.
    task automatic apply_random_setting();
        int          lim [NUM_THR];
        int          tmp;
        int          mode;
        logic [THR_REG_W-1:0] limits;
        t_color_bank colors;
        mode = $urandom_range(7);
        for (int k = 0; k < NUM_THR; k++) begin
            lim[k] = $urandom_range(16'hFFFF);
        end
        for (int i = 0; i < NUM_THR; i++) begin
            for (int j = 0; j + 1 < NUM_THR - i; j++) begin
                if (lim[j] > lim[j + 1]) begin
                    tmp = lim[j];
                    lim[j] = lim[j + 1];
                    lim[j + 1] = tmp;
                end
            end
        end
        if (mode == 4) begin
            lim[0] = 0;
            lim[NUM_THR - 1] = 16'hFFFF;
        end
        limits = pack_limits(lim[0], lim[1], lim[2], lim[3]);
        if (mode == 5) begin
            limits = {$urandom(), $urandom()};
        end else if (mode == 6) begin
            limits = '0;
        end else if (mode == 7) begin
            limits = '1;
        end
        for (int b = 0; b < COLOR_REGS; b++) begin
            case ($urandom_range(7))
                0: colors[b] = '0;
                1: colors[b] = '1;
                default: colors[b] = COLOR_W'($urandom());
            endcase
        end
        apply_setting(1'b1, limits, colors);
    endtask

    // Heights: mostly in range, many near a threshold, some anywhere.
    function automatic int pick_height();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            return $urandom_range(16'hFFFF);
        end else if (pick < 75) begin
            return int'(band_limit($urandom_range(NUM_THR - 1))) + $urandom_range(4) - 2;
        end else if (pick < 92) begin
            return int'($urandom());
        end
        case ($urandom_range(3))
            0: return -131072;
            1: return 131071;
            2: return 0;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_random_setting();
            // One phase runs with no idling on either side.
            send_idle_pct = (p == 3) ? 0 : 10;
            recv_idle_pct = (p == 3) ? 0 : 10;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
                    hold_until_drained();
                end
                send_height(pick_height());
            end
        end
        send_idle_pct = 10;
        recv_idle_pct = 10;
    endtask

    initial begin
        for (int b = 0; b < COLOR_REGS; b++) begin
            palette_mirror[b] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_default_limits();
        test_band_edges();
        test_zero_span_and_top();
        test_unsorted_and_spare();
        test_random_phases();

        wait_idle();
        $display("Sent %0d heights and checked %0d colors under %0d settings.",
                 heights_sent, colors_checked, settings_loaded);
        $display("Register writes taken: %0d, mismatches: %0d.", reg_writes, mismatch_count);
        if (mismatch_count == 0 && expected_colors.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
